// ===== sv/sktab_pkg.sv =====
// Shared types, sizes and codes for the sorted key/value table.
`default_nettype none

package sktab_pkg;

  // Storage sizes
  localparam int unsigned CAPACITY    = 64;
  localparam int unsigned KEY_WIDTH   = 32;
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned IDX_W       = $clog2(CAPACITY);
  localparam int unsigned CNT_W       = $clog2(CAPACITY + 1);

  // Fixed field widths of the request and result
  localparam int unsigned KIND_IN_W = 3;
  localparam int unsigned KEY_IN_W  = 32;
  localparam int unsigned VAL_IN_W  = 32;
  localparam int unsigned CNT_OUT_W = 7;

  typedef enum logic [KIND_IN_W-1:0] {
    OP_INSERT_NEW    = 3'd0,
    OP_INSERT_OR_GET = 3'd1,
    OP_FIND          = 3'd2,
    OP_SET_EXISTING  = 3'd3,
    OP_ERASE         = 3'd4,
    OP_CLEAR         = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_PRESENT = 2'd1,
    STS_MISSING = 2'd2,
    STS_FULL    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_COMPARE,
    S_CHECK,
    S_PRIME,
    S_SHIFT,
    S_WRITE,
    S_DONE
  } state_e;

  typedef enum logic [1:0] {
    RD_PROBE,
    RD_PRIME,
    RD_NEXT
  } rd_sel_e;

  typedef struct packed {
    logic [KIND_IN_W-1:0] kind;
    logic [KEY_IN_W-1:0]  key;
    logic [VAL_IN_W-1:0]  value;
  } req_t;

  typedef struct packed {
    status_e              status;
    logic [VAL_IN_W-1:0]  value_out;
    logic [CNT_OUT_W-1:0] entry_count_out;
  } rsp_t;

  typedef struct packed {
    logic [KEY_WIDTH-1:0]   key;
    logic [VALUE_WIDTH-1:0] value;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic    load;
    logic    step;
    logic    check;
    logic    wr_set;
    logic    shift;
    logic    wr_new;
    rd_sel_e rd_sel;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic                 len_zero;
    logic                 hit;
    logic                 full;
    logic                 need_shift;
    logic                 shift_last;
    logic [KIND_IN_W-1:0] kind;
  } sts_t;

endpackage

`default_nettype wire

// ===== sv/sktab_ctrl.sv =====
// Sequencing state machine for the sorted key/value table.
`default_nettype none

module sktab_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  output logic               done_o,
  input  wire sktab_pkg::sts_t sts_i,
  output sktab_pkg::cmd_t    cmd_o
);
  import sktab_pkg::*;

  state_e state_q, state_d;
  logic   is_insert;

  assign is_insert = (sts_i.kind == OP_INSERT_NEW) || (sts_i.kind == OP_INSERT_OR_GET);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start) state_d = S_SEARCH;
      end
      S_SEARCH: begin
        state_d = sts_i.len_zero ? S_CHECK : S_COMPARE;
      end
      S_COMPARE: begin
        state_d = S_SEARCH;
      end
      S_CHECK: begin
        state_d = S_DONE;
        if (is_insert) begin
          if (!sts_i.hit && !sts_i.full) begin
            state_d = sts_i.need_shift ? S_PRIME : S_WRITE;
          end
        end else if (sts_i.kind == OP_ERASE) begin
          if (sts_i.hit && sts_i.need_shift) state_d = S_PRIME;
        end
      end
      S_PRIME: begin
        state_d = S_SHIFT;
      end
      S_SHIFT: begin
        if (sts_i.shift_last) state_d = is_insert ? S_WRITE : S_DONE;
      end
      S_WRITE: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        state_d = start ? S_SEARCH : S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o        = '0;
    cmd_o.rd_sel = RD_PROBE;
    busy         = 1'b1;
    done_o       = 1'b0;
    case (state_q)
      S_IDLE: begin
        busy       = 1'b0;
        cmd_o.load = start;
      end
      S_SEARCH: begin
        cmd_o.rd_sel = RD_PROBE;
      end
      S_COMPARE: begin
        cmd_o.step = 1'b1;
      end
      S_CHECK: begin
        cmd_o.check  = 1'b1;
        cmd_o.wr_set = (sts_i.kind == OP_SET_EXISTING) && sts_i.hit;
      end
      S_PRIME: begin
        cmd_o.rd_sel = RD_PRIME;
      end
      S_SHIFT: begin
        cmd_o.shift  = 1'b1;
        cmd_o.rd_sel = RD_NEXT;
      end
      S_WRITE: begin
        cmd_o.wr_new = 1'b1;
      end
      S_DONE: begin
        busy       = 1'b0;
        done_o     = 1'b1;
        cmd_o.load = start;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/sktab_dp.sv =====
// Datapath: entry memory, search bounds, shift pointer, count and result register.
`default_nettype none

module sktab_dp (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire sktab_pkg::req_t req_i,
  input  wire sktab_pkg::cmd_t cmd_i,
  output sktab_pkg::sts_t      sts_o,
  output sktab_pkg::rsp_t      rsp_o
);
  import sktab_pkg::*;

  entry_t mem [CAPACITY];
  entry_t rd_q;

  logic [KIND_IN_W-1:0]   kind_q;
  logic [KEY_WIDTH-1:0]   key_q;
  logic [VALUE_WIDTH-1:0] value_q;

  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] first_q, first_d;
  logic [CNT_W-1:0] len_q, len_d;
  logic [CNT_W-1:0] dst_q, dst_d;
  logic [CNT_W-1:0] end_q, end_d;
  logic             up_q, up_d;
  rsp_t             rsp_q, rsp_d;

  logic [CNT_W-1:0] half;
  logic [CNT_W-1:0] mid;
  logic [CNT_W-1:0] rd_addr;
  logic             hit;
  logic             full;
  logic             wr_en;
  logic [CNT_W-1:0] wr_addr;
  entry_t           wr_data;

  assign half = len_q >> 1;
  assign mid  = first_q + half;
  assign hit  = (first_q < count_q) && (rd_q.key == key_q);
  assign full = (count_q == CNT_W'(CAPACITY));

  assign sts_o.len_zero   = (len_q == '0);
  assign sts_o.hit        = hit;
  assign sts_o.full       = full;
  assign sts_o.need_shift = (kind_q == OP_ERASE) ? ((first_q + 1'b1) != count_q)
                                                 : (first_q != count_q);
  assign sts_o.shift_last = (dst_q == end_q);
  assign sts_o.kind       = kind_q;

  // Read address: search probe, or source of the first / next shift move
  always_comb begin
    case (cmd_i.rd_sel)
      RD_PROBE: rd_addr = mid;
      RD_PRIME: rd_addr = up_q ? (dst_q - 1'b1) : (dst_q + 1'b1);
      RD_NEXT:  rd_addr = up_q ? (dst_q - 2'd2) : (dst_q + 2'd2);
      default:  rd_addr = mid;
    endcase
  end

  // Write port
  always_comb begin
    wr_en   = cmd_i.shift || cmd_i.wr_set || cmd_i.wr_new;
    wr_addr = cmd_i.shift ? dst_q : first_q;
    wr_data = cmd_i.shift ? rd_q : entry_t'{key: key_q, value: value_q};
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr[IDX_W-1:0]] <= wr_data;
    rd_q <= mem[rd_addr[IDX_W-1:0]];
  end

  // Bounds, shift pointer, count and result
  always_comb begin
    first_d = first_q;
    len_d   = len_q;
    dst_d   = dst_q;
    end_d   = end_q;
    up_d    = up_q;
    count_d = count_q;
    rsp_d   = rsp_q;

    if (cmd_i.load) begin
      first_d = '0;
      len_d   = count_q;
    end

    if (cmd_i.step) begin
      if (rd_q.key < key_q) begin
        first_d = mid + 1'b1;
        len_d   = len_q - half - 1'b1;
      end else begin
        len_d = half;
      end
    end

    if (cmd_i.shift) begin
      dst_d = up_q ? (dst_q - 1'b1) : (dst_q + 1'b1);
    end

    if (cmd_i.check) begin
      rsp_d.status    = STS_OK;
      rsp_d.value_out = '0;
      case (kind_q)
        OP_INSERT_NEW, OP_INSERT_OR_GET: begin
          if (hit) begin
            rsp_d.status    = STS_PRESENT;
            rsp_d.value_out = VAL_IN_W'(rd_q.value);
          end else if (full) begin
            rsp_d.status = STS_FULL;
          end else begin
            rsp_d.value_out = VAL_IN_W'(value_q);
            count_d         = count_q + 1'b1;
            dst_d           = count_q;
            end_d           = first_q + 1'b1;
            up_d            = 1'b1;
          end
        end
        OP_FIND: begin
          if (hit) rsp_d.value_out = VAL_IN_W'(rd_q.value);
          else     rsp_d.status    = STS_MISSING;
        end
        OP_SET_EXISTING: begin
          if (hit) rsp_d.value_out = VAL_IN_W'(value_q);
          else     rsp_d.status    = STS_MISSING;
        end
        OP_ERASE: begin
          if (hit) begin
            rsp_d.value_out = VAL_IN_W'(rd_q.value);
            count_d         = count_q - 1'b1;
            dst_d           = first_q;
            end_d           = count_q - 2'd2;
            up_d            = 1'b0;
          end else begin
            rsp_d.status = STS_MISSING;
          end
        end
        OP_CLEAR: begin
          count_d = '0;
        end
        default: begin
          count_d = count_q;
        end
      endcase
      rsp_d.entry_count_out = CNT_OUT_W'(count_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q  <= req_i.kind;
      key_q   <= KEY_WIDTH'(req_i.key);
      value_q <= VALUE_WIDTH'(req_i.value);
    end
    first_q <= first_d;
    len_q   <= len_d;
    dst_q   <= dst_d;
    end_q   <= end_d;
    up_q    <= up_d;
    rsp_q   <= rsp_d;
  end

  assign rsp_o = rsp_q;

endmodule

`default_nettype wire

// ===== sv/sorted_key_value_table.sv =====
// Top level of the sorted key/value table: controller plus datapath.
//
//   channel   ports                     handshake
//   --------  ------------------------  -----------------------------------
//   request   req_i {kind,key,value}    taken at an edge with start & !busy
//   result    rsp_o {status,value_out,  shown for one cycle while done_o is
//             entry_count_out}          high, taken at the edge ending it
//
// Every request runs a lower-bound binary search over the entry memory: each
// probe is a read, then a compare; at most log2(count)+1 probes. A final
// read, a check step and the strobe cycle follow; for an insert or erase
// the entries above the position move one place per cycle through the
// single write port (plus one priming read), and an insert then writes
// its new pair in a write step.
// Reset clears the entry count only; the memory needs no clearing pass.
// The result strobe cycle already accepts the next request; the receiver
// cannot stall the block.
`default_nettype none

module sorted_key_value_table (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  output logic                 busy,
  input  wire sktab_pkg::req_t req_i,
  output logic                 done_o,
  output sktab_pkg::rsp_t      rsp_o
);
  import sktab_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Hold the sequence: search, check, shift, write, report
  sktab_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // Advance the search bounds, move the entries and register the result
  sktab_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .rsp_o  (rsp_o)
  );

endmodule

`default_nettype wire

// ===== tb/sorted_key_value_table_tb.sv =====
// Self-checking testbench for the sorted key/value table: random and directed requests.
`default_nettype none

module sorted_key_value_table_tb;
  import sktab_pkg::*;

  // Kinds outside the defined operations; the block must treat them as no-ops
  localparam logic [KIND_IN_W-1:0] OP_RESERVED_LO = 3'd6;
  localparam logic [KIND_IN_W-1:0] OP_RESERVED_HI = 3'd7;

  localparam int unsigned RANDOM_ITEMS = 500;
  // Leave room after the last result, beyond the slowest request
  localparam int unsigned TAIL_CYCLES  = 120;

  typedef struct {
    req_t req;
    int   gap;    // idle cycles before this request is offered
    bit   drain;  // hold off until every outstanding result has come back
  } pending_req_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  req_t req_i  = '0;
  logic busy;
  logic done_o;
  rsp_t rsp_o;

  sorted_key_value_table u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Run limit: far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Table shadow: keys ascending, unique, only entries below shadow_count valid
  // ---------------------------------------------------------------------------
  logic [KEY_IN_W-1:0] shadow_keys [CAPACITY];
  logic [VAL_IN_W-1:0] shadow_vals [CAPACITY];
  int                  shadow_count = 0;

  int status_tally [4];
  int peak_count  = 0;
  int clear_count = 0;

  // First position whose key is not below the search key
  function automatic int search_slot(input logic [KEY_IN_W-1:0] key);
    int lo;
    int len;
    int half;
    lo  = 0;
    len = shadow_count;
    while (len > 0) begin
      half = len >> 1;
      if (shadow_keys[lo + half] < key) begin
        lo  = lo + half + 1;
        len = len - half - 1;
      end else begin
        len = half;
      end
    end
    return lo;
  endfunction

  // Apply one request to the shadow and return the result the block must give
  task automatic table_update(input req_t r, output rsp_t rsp);
    int pos;
    int i;
    bit hit;
    pos = search_slot(r.key);
    hit = (pos < shadow_count) && (shadow_keys[pos] == r.key);
    rsp = '0;
    rsp.status = STS_OK;
    case (r.kind)
      OP_INSERT_NEW, OP_INSERT_OR_GET: begin
        if (hit) begin
          rsp.status    = STS_PRESENT;
          rsp.value_out = shadow_vals[pos];
        end else if (shadow_count >= CAPACITY) begin
          rsp.status = STS_FULL;
        end else begin
          // open a slot at the search position
          for (i = shadow_count; i > pos; i--) begin
            shadow_keys[i] = shadow_keys[i - 1];
            shadow_vals[i] = shadow_vals[i - 1];
          end
          shadow_keys[pos] = r.key;
          shadow_vals[pos] = r.value;
          shadow_count++;
          rsp.value_out = r.value;
        end
      end
      OP_FIND: begin
        if (hit) rsp.value_out = shadow_vals[pos];
        else     rsp.status    = STS_MISSING;
      end
      OP_SET_EXISTING: begin
        if (hit) begin
          shadow_vals[pos] = r.value;
          rsp.value_out    = r.value;
        end else begin
          rsp.status = STS_MISSING;
        end
      end
      OP_ERASE: begin
        if (hit) begin
          rsp.value_out = shadow_vals[pos];
          for (i = pos; i + 1 < shadow_count; i++) begin
            shadow_keys[i] = shadow_keys[i + 1];
            shadow_vals[i] = shadow_vals[i + 1];
          end
          shadow_count--;
        end else begin
          rsp.status = STS_MISSING;
        end
      end
      OP_CLEAR: begin
        shadow_count = 0;
        clear_count++;
      end
      default: ;
    endcase
    rsp.entry_count_out = CNT_OUT_W'(shadow_count);
    status_tally[rsp.status]++;
    if (shadow_count > peak_count) peak_count = shadow_count;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus construction
  // ---------------------------------------------------------------------------
  pending_req_t        pend_q [$];
  logic [KEY_IN_W-1:0] recent_keys [$];
  int                  items_queued = 0;
  bit                  burst_mode   = 1'b0;
  bit                  drain_next   = 1'b0;

  task automatic push_request(input logic [KIND_IN_W-1:0] kind,
                              input logic [KEY_IN_W-1:0]  key,
                              input logic [VAL_IN_W-1:0]  value);
    pending_req_t p;
    p.req.kind  = kind;
    p.req.key   = key;
    p.req.value = value;
    p.gap       = burst_mode ? 0 : $urandom_range(0, 4);
    p.drain     = drain_next;
    drain_next  = 1'b0;
    pend_q.push_back(p);
    items_queued++;
    // remember inserted keys so later finds and erases mostly hit
    if (kind == OP_INSERT_NEW || kind == OP_INSERT_OR_GET) begin
      recent_keys.push_back(key);
      if (recent_keys.size() > 96) void'(recent_keys.pop_front());
    end
  endtask

  function automatic logic [KEY_IN_W-1:0] pick_key();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60 && recent_keys.size() != 0)
      return recent_keys[$urandom_range(0, recent_keys.size() - 1)];
    if (r < 72) begin
      case ($urandom_range(0, 3))
        0:       return '0;
        1:       return 32'h0000_0001;
        2:       return '1;
        default: return 32'hFFFF_FFFE;
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic [VAL_IN_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  function automatic logic [KIND_IN_W-1:0] pick_kind();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 22) return OP_INSERT_NEW;
    if (r < 40) return OP_INSERT_OR_GET;
    if (r < 58) return OP_FIND;
    if (r < 72) return OP_SET_EXISTING;
    if (r < 92) return OP_ERASE;
    if (r < 96) return ($urandom_range(0, 1) != 0) ? OP_RESERVED_LO : OP_RESERVED_HI;
    return OP_CLEAR;
  endfunction

  task automatic build_directed();
    // empty table: every lookup misses
    push_request(OP_FIND,          32'h1234_5678, '0);
    push_request(OP_ERASE,         '0,            '1);
    push_request(OP_SET_EXISTING,  '1,            '1);
    // key and value extremes
    push_request(OP_INSERT_NEW,    '0,            '0);
    push_request(OP_INSERT_NEW,    '1,            '1);
    push_request(OP_INSERT_NEW,    32'h8000_0000, 32'hA5A5_5A5A);
    push_request(OP_INSERT_NEW,    '0,            32'h5555_5555);   // already present
    push_request(OP_INSERT_OR_GET, '1,            32'h0000_0001);   // already present
    push_request(OP_INSERT_OR_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFE);   // absent, lands in middle
    push_request(OP_FIND,          '1,            '0);
    push_request(OP_FIND,          32'h4000_0000, '0);              // miss between entries
    push_request(OP_SET_EXISTING,  32'h8000_0000, 32'hDEAD_BEEF);
    push_request(OP_SET_EXISTING,  32'h8000_0001, 32'h1111_1111);
    push_request(OP_FIND,          32'h8000_0000, '0);
    push_request(OP_ERASE,         32'h7FFF_FFFF, '0);              // erase from the middle
    push_request(OP_ERASE,         32'h7FFF_FFFE, '0);
    push_request(OP_ERASE,         '0,            '0);              // erase lowest entry
    push_request(OP_ERASE,         '1,            '0);              // erase highest entry
    push_request(OP_RESERVED_LO,   '1,            '1);
    push_request(OP_RESERVED_HI,   '0,            '1);
    push_request(OP_FIND,          32'h8000_0000, '0);
    push_request(OP_CLEAR,         '1,            '1);
    push_request(OP_FIND,          32'h8000_0000, '0);              // gone after clear
    push_request(OP_INSERT_OR_GET, 32'h0000_0001, 32'hFFFF_0000);
  endtask

  // Fill to near or past capacity so inserts can hit the full case, with a present key too
  task automatic build_fill();
    int n;
    int i;
    n = $urandom_range(62, 72);
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 6) == 0)
        push_request(($urandom_range(0, 1) != 0) ? OP_INSERT_NEW : OP_INSERT_OR_GET,
                     pick_key(), pick_value());
      else
        push_request(($urandom_range(0, 1) != 0) ? OP_INSERT_NEW : OP_INSERT_OR_GET,
                     $urandom, pick_value());
    end
    push_request(OP_INSERT_NEW, $urandom, pick_value());
    push_request(OP_INSERT_OR_GET, recent_keys[recent_keys.size() - 1], pick_value());
  endtask

  task automatic build_random();
    int phase;
    int n;
    int i;
    bit first;
    first = 1'b1;
    while (items_queued < RANDOM_ITEMS) begin
      burst_mode = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 7) == 0) drain_next = 1'b1;
      phase = first ? 6 : $urandom_range(0, 9);
      first = 1'b0;
      case (phase)
        6: build_fill();
        7: begin
          // run the table down with erases that mostly hit
          n = $urandom_range(10, 30);
          for (i = 0; i < n; i++) push_request(OP_ERASE, pick_key(), pick_value());
        end
        8: begin
          push_request(OP_CLEAR, $urandom, $urandom);
          n = $urandom_range(3, 10);
          for (i = 0; i < n; i++) push_request(OP_INSERT_NEW, pick_key(), pick_value());
        end
        default: begin
          n = $urandom_range(10, 25);
          for (i = 0; i < n; i++) push_request(pick_kind(), pick_key(), pick_value());
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Request driver: change inputs on the falling edge only
  // ---------------------------------------------------------------------------
  pending_req_t cur_req;
  bit           have_cur   = 1'b0;
  int           n_issued   = 0;
  int           n_accepted = 0;
  rsp_t         predicted_rsp_q [$];

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (!(start && n_accepted != n_issued)) begin
      // previous request taken (or none offered): line up the next one
      if (!have_cur && pend_q.size() != 0) begin
        cur_req  = pend_q.pop_front();
        have_cur = 1'b1;
      end
      if (have_cur && cur_req.gap != 0) begin
        cur_req.gap--;
        start <= 1'b0;
      end else if (have_cur && cur_req.drain && predicted_rsp_q.size() != 0) begin
        // hold until the block has answered everything outstanding
        start <= 1'b0;
      end else if (have_cur) begin
        req_i    <= cur_req.req;
        start    <= 1'b1;
        n_issued++;
        have_cur = 1'b0;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check results and record accepted requests on the rising edge
  // ---------------------------------------------------------------------------
  int fail_count = 0;
  int n_checked  = 0;

  always @(posedge clk_i) begin : mon
    rsp_t want;
    rsp_t fresh;
    if (rst_ni) begin
      // check the result before recording a request taken on the same edge
      if (done_o) begin
        if (predicted_rsp_q.size() == 0) begin
          $display("%0t: result with none outstanding: status %0d value %h count %0d",
                   $time, rsp_o.status, rsp_o.value_out, rsp_o.entry_count_out);
          fail_count++;
        end else begin
          want = predicted_rsp_q.pop_front();
          n_checked++;
          if (rsp_o.status !== want.status) begin
            $display("%0t: status mismatch: expected %0d, got %0d",
                     $time, want.status, rsp_o.status);
            fail_count++;
          end
          if (rsp_o.value_out !== want.value_out) begin
            $display("%0t: value_out mismatch: expected %h, got %h",
                     $time, want.value_out, rsp_o.value_out);
            fail_count++;
          end
          if (rsp_o.entry_count_out !== want.entry_count_out) begin
            $display("%0t: entry_count_out mismatch: expected %0d, got %0d",
                     $time, want.entry_count_out, rsp_o.entry_count_out);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        table_update(req_i, fresh);
        predicted_rsp_q.push_back(fresh);
        n_accepted++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencing: build stimulus, release reset, wait for every result
  // ---------------------------------------------------------------------------
  initial begin
    build_directed();
    // first random request waits for the directed results to drain
    drain_next = 1'b1;
    build_random();

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (n_checked != items_queued) @(posedge clk_i);
    // let any stray result show up before the verdict
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("%0d requests checked: %0d done, %0d present, %0d missing, %0d full",
             n_checked, status_tally[STS_OK], status_tally[STS_PRESENT],
             status_tally[STS_MISSING], status_tally[STS_FULL]);
    $display("peak occupancy %0d of %0d entries, %0d clears", peak_count, CAPACITY,
             clear_count);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
sv/sktab_pkg.sv
sv/sktab_ctrl.sv
sv/sktab_dp.sv
sv/sorted_key_value_table.sv
tb/sorted_key_value_table_tb.sv
